>>> hw/rtl/esd_pkg.sv
// esd_pkg: shared types and constants of the event and sub-frame deframer
// no dependencies; imported by the interfaces and every deframer module

package esd_pkg;

  // width of the length fields on the result channel
  localparam int LenOutBits = 24;

  // depth of the queue between the front and back parts
  localparam int QueueDepth = 4;
  localparam int QptrBits   = $clog2(QueueDepth);

  // register map, byte address 4*i
  localparam int RegAddrBits = 4;
  localparam logic [1:0] REG_EVENT_TRAILER    = 2'd0;
  localparam logic [1:0] REG_HEADER           = 2'd1;
  localparam logic [1:0] REG_SUBFRAME_TRAILER = 2'd2;
  localparam logic [1:0] REG_LAYER_MARKER     = 2'd3;

  // register reset values
  localparam logic [31:0] EVENT_TRAILER_RST    = 32'hFEDD_FEDD;
  localparam logic [31:0] HEADER_RST           = 32'hFA5A_FA5A;
  localparam logic [31:0] SUBFRAME_TRAILER_RST = 32'hFEEE_FEEE;
  localparam logic [7:0]  LAYER_MARKER_RST     = 8'hFF;

  // match words seen by the back part
  typedef struct packed {
    logic [31:0] event_trailer_word;
    logic [31:0] header_word;
    logic [31:0] subframe_trailer_word;
  } esd_words_t;

  // one queued byte, tagged by the front part
  typedef struct packed {
    logic [7:0] data_byte;
    logic       layer_hit;
  } esd_entry_t;

  // queue status toward the neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } esd_qstat_t;

endpackage

>>> hw/rtl/esd_ifs.sv
// esd_ifs: valid/ready channels of the deframer (raw bytes in, tagged bytes out)
// depends on esd_pkg

interface esd_byte_if import esd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface esd_tag_if import esd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [7:0]            byte_out;
  logic                  event_end;
  logic [LenOutBits-1:0] event_length;
  logic                  header_found;
  logic                  subframe_end;
  logic [LenOutBits-1:0] subframe_length;
  logic                  bad_layer;

  modport source (output valid, output byte_out, output event_end, output event_length,
                  output header_found, output subframe_end, output subframe_length,
                  output bad_layer, input ready);
  modport sink   (input valid, input byte_out, input event_end, input event_length,
                  input header_found, input subframe_end, input subframe_length,
                  input bad_layer, output ready);
endinterface

>>> hw/rtl/esd_front.sv
// esd_front: accepts raw bytes, tags layer-marker bytes, feeds the queue
// depends on esd_pkg

module esd_front import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [7:0] layer_marker,
  output logic       push,
  output esd_entry_t push_entry,
  input  esd_qstat_t qstat
);

  logic       stage_valid;
  esd_entry_t stage;

  // stage moves on whenever the queue has room
  assign push       = stage_valid && !qstat.full;
  assign push_entry = stage;
  assign in_ready   = !stage_valid || !qstat.full;

  // input register with layer tag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage.data_byte <= in_byte;
      stage.layer_hit <= (in_byte == layer_marker);
    end
  end

endmodule

>>> hw/rtl/esd_queue.sv
// esd_queue: small fifo of tagged bytes between the front and back parts
// depends on esd_pkg

module esd_queue import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  esd_entry_t push_entry,
  input  logic       pop,
  output esd_entry_t head,
  output esd_qstat_t qstat
);

  esd_entry_t          entries [QueueDepth];
  logic [QptrBits-1:0] wr_ptr;
  logic [QptrBits-1:0] rd_ptr;
  logic [QptrBits:0]   count;

  assign qstat.full  = (count == (QptrBits+1)'(QueueDepth));
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/esd_back.sv
// esd_back: match window, length counters, trailer phase and result register
// depends on esd_pkg

module esd_back import esd_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  esd_words_t      words,
  input  esd_entry_t      head,
  input  esd_qstat_t      qstat,
  output logic            pop,
  esd_tag_if.source       res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LAYER = 2'd1,
    PH_CLOSE = 2'd2
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] CntMax = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CntFour = LENGTH_BITS'(4);

  logic [31:0]            window, window_next, win;
  logic [LENGTH_BITS-1:0] ev_cnt, ev_cnt_next, ev_inc;
  logic [LENGTH_BITS-1:0] sf_cnt, sf_cnt_next, sf_inc;
  phase_t                 phase, phase_next;
  logic                   armed;
  logic                   r_event_end, r_header, r_sf_end, r_bad;
  logic [LenOutBits-1:0]  r_ev_len, r_sf_len;

  // count to result field width
  function automatic logic [LenOutBits-1:0] to_out(input logic [LENGTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[LenOutBits-1:0];
  endfunction

  // take the next byte when the result register is free or being taken
  assign pop = !qstat.empty && (!res.valid || res.ready);

  // window and saturating counts
  always_comb begin
    win    = {window[23:0], head.data_byte};
    ev_inc = (ev_cnt == CntMax) ? ev_cnt : ev_cnt + 1'b1;
    sf_inc = (sf_cnt == CntMax) ? sf_cnt : sf_cnt + 1'b1;
    armed  = (ev_inc >= CntFour);
  end

  // classify the byte and update state
  always_comb begin
    window_next = win;
    ev_cnt_next = ev_inc;
    sf_cnt_next = sf_inc;
    phase_next  = phase;
    r_event_end = 1'b0;
    r_ev_len    = '0;
    r_header    = 1'b0;
    r_sf_end    = 1'b0;
    r_sf_len    = '0;
    r_bad       = 1'b0;
    if (armed && win == words.event_trailer_word) begin
      // event end wins and clears everything
      r_event_end = 1'b1;
      r_ev_len    = to_out(ev_inc);
      window_next = '0;
      ev_cnt_next = '0;
      sf_cnt_next = '0;
      phase_next  = PH_IDLE;
    end else begin
      case (phase)
        PH_LAYER: begin
          if (head.layer_hit) begin
            phase_next = PH_CLOSE;
          end else begin
            r_bad      = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_CLOSE: begin
          r_sf_end    = 1'b1;
          r_sf_len    = to_out(sf_inc);
          sf_cnt_next = ev_inc;
          phase_next  = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      // header restarts the sub-frame count at its own four bytes
      if (armed && win == words.header_word) begin
        r_header    = 1'b1;
        sf_cnt_next = CntFour;
      end
      // sub-frame trailer arms the layer byte check
      if (armed && win == words.subframe_trailer_word) begin
        phase_next = PH_LAYER;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      ev_cnt    <= '0;
      sf_cnt    <= '0;
      phase     <= PH_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (pop) begin
        window    <= window_next;
        ev_cnt    <= ev_cnt_next;
        sf_cnt    <= sf_cnt_next;
        phase     <= phase_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
    if (pop) begin
      res.byte_out        <= head.data_byte;
      res.event_end       <= r_event_end;
      res.event_length    <= r_ev_len;
      res.header_found    <= r_header;
      res.subframe_end    <= r_sf_end;
      res.subframe_length <= r_sf_len;
      res.bad_layer       <= r_bad;
    end
  end

endmodule

>>> hw/rtl/event_and_subframe_deframer.sv
// event_and_subframe_deframer: top level with register port, front, queue and back
// depends on esd_pkg, esd_ifs, esd_front, esd_queue, esd_back
//
// Usage:
//   raw_bytes takes one raw stream byte per transaction (valid/ready).
//   tagged_bytes gives exactly one result per byte: the byte itself, event end
//   with event length, header found, sub-frame end with sub-frame length, and
//   a bad layer flag. Lengths saturate at 2^LENGTH_BITS - 1.
//   The result passes the input register, the queue and the result register
//   before it is valid on tagged_bytes.
//   Throughput is one byte per clock while tagged_bytes takes results, set
//   by the combinational window compare and counter update in the back part.
//   When tagged_bytes stalls, the result register holds; the 4-entry queue and
//   the input register keep taking bytes until full, then raw_bytes.ready drops.
//   Reset (rst, synchronous) empties the queue, clears window, counts and
//   trailer phase, and loads the default match words and layer marker.
//   The user writes the APB port (registers at 4*i) only while no byte is in flight; the block does not enforce it.

module event_and_subframe_deframer import esd_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  esd_byte_if.sink               raw_bytes,
  esd_tag_if.source              tagged_bytes,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RegAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  esd_words_t  words;
  logic [7:0]  layer_marker;
  logic        cfg_write;
  logic [1:0]  reg_index;
  logic        push;
  logic        pop;
  esd_entry_t  push_entry;
  esd_entry_t  head;
  esd_qstat_t  qstat;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      words.event_trailer_word    <= EVENT_TRAILER_RST;
      words.header_word           <= HEADER_RST;
      words.subframe_trailer_word <= SUBFRAME_TRAILER_RST;
      layer_marker                <= LAYER_MARKER_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_EVENT_TRAILER:    words.event_trailer_word    <= pwdata;
        REG_HEADER:           words.header_word           <= pwdata;
        REG_SUBFRAME_TRAILER: words.subframe_trailer_word <= pwdata;
        REG_LAYER_MARKER:     layer_marker                <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      REG_EVENT_TRAILER:    prdata = words.event_trailer_word;
      REG_HEADER:           prdata = words.header_word;
      REG_SUBFRAME_TRAILER: prdata = words.subframe_trailer_word;
      REG_LAYER_MARKER:     prdata = {24'd0, layer_marker};
      default:              prdata = '0;
    endcase
  end

  // front part
  esd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (raw_bytes.valid),
    .in_ready     (raw_bytes.ready),
    .in_byte      (raw_bytes.data_byte),
    .layer_marker (layer_marker),
    .push         (push),
    .push_entry   (push_entry),
    .qstat        (qstat)
  );

  // queue between the parts
  esd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // back part
  esd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .words (words),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .res   (tagged_bytes)
  );

  // queue is never full and empty at once
  a_qstat: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

  // a pop needs a queued byte
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // event end excludes every sub-frame tag
  a_event_excl: assert property (@(posedge clk) disable iff (rst)
    (tagged_bytes.valid && tagged_bytes.event_end) |->
      (!tagged_bytes.header_found && !tagged_bytes.subframe_end && !tagged_bytes.bad_layer))
    else $error("event end with sub-frame tag");

  // a close and a bad layer byte never meet
  a_close_bad: assert property (@(posedge clk) disable iff (rst)
    tagged_bytes.valid |-> !(tagged_bytes.subframe_end && tagged_bytes.bad_layer))
    else $error("sub-frame end with bad layer");

endmodule

>>> verif/event_and_subframe_deframer_tb.sv
`timescale 1ns / 100ps
// event_and_subframe_deframer_tb: self-checking testbench of the event and sub-frame deframer
// sends raw byte streams under several register settings and checks every tagged byte
// depends on esd_pkg, esd_ifs and the deframer rtl

module event_and_subframe_deframer_tb;
  import esd_pkg::*;

  localparam int LengthBits = 24;
  localparam logic [LengthBits-1:0] CountMax = '1;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems = 145;
  localparam int ReportLimit = 10;

  // sub-frame trailer tracking
  typedef enum logic [1:0] {PH_IDLE, PH_LAYER, PH_CLOSE} trailer_phase_t;

  // one tagged byte as seen on the result channel
  typedef struct packed {
    logic [7:0]            byte_out;
    logic                  event_end;
    logic [LenOutBits-1:0] event_length;
    logic                  header_found;
    logic                  subframe_end;
    logic [LenOutBits-1:0] subframe_length;
    logic                  bad_layer;
  } tag_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [RegAddrBits-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  esd_byte_if raw_if ();
  esd_tag_if  tag_if ();

  event_and_subframe_deframer #(.LENGTH_BITS(LengthBits)) DUT (
    .clk          (clk),
    .rst          (rst),
    .raw_bytes    (raw_if),
    .tagged_bytes (tag_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the match words and the deframing state
  logic [31:0]           event_trailer_cfg    = EVENT_TRAILER_RST;
  logic [31:0]           header_cfg           = HEADER_RST;
  logic [31:0]           subframe_trailer_cfg = SUBFRAME_TRAILER_RST;
  logic [7:0]            layer_cfg            = LAYER_MARKER_RST;
  logic [31:0]           match_window         = '0;
  logic [LengthBits-1:0] event_count          = '0;
  logic [LengthBits-1:0] subframe_count       = '0;
  trailer_phase_t        close_phase          = PH_IDLE;

  logic [7:0] raw_byte_q[$];
  tag_t       expected_tags[$];
  int         pushed_count   = 0;
  int         result_count   = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_wait;
  int         recv_wait;
  int         send_pace      = 0;
  int         recv_pace      = 0;

  function automatic logic [LengthBits-1:0] sat_inc(input logic [LengthBits-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // tag one raw byte and advance the deframing state
  function automatic tag_t deframe_byte(input logic [7:0] b);
    tag_t t;
    logic armed;
    t = '0;
    t.byte_out = b;
    match_window = {match_window[23:0], b};
    event_count = sat_inc(event_count);
    subframe_count = sat_inc(subframe_count);
    armed = (event_count >= 4);
    if (armed && match_window == event_trailer_cfg) begin
      // event end wins and drops any pending sub-frame
      t.event_end = 1'b1;
      t.event_length = event_count;
      match_window = '0;
      event_count = '0;
      subframe_count = '0;
      close_phase = PH_IDLE;
    end else begin
      case (close_phase)
        PH_LAYER: begin
          if (b == layer_cfg) begin
            close_phase = PH_CLOSE;
          end else begin
            t.bad_layer = 1'b1;
            close_phase = PH_IDLE;
          end
        end
        PH_CLOSE: begin
          t.subframe_end = 1'b1;
          t.subframe_length = subframe_count;
          subframe_count = event_count;
          close_phase = PH_IDLE;
        end
        default: close_phase = PH_IDLE;
      endcase
      // a header restarts the count at its own four bytes
      if (armed && match_window == header_cfg) begin
        t.header_found = 1'b1;
        subframe_count = LengthBits'(4);
      end
      if (armed && match_window == subframe_trailer_cfg) close_phase = PH_LAYER;
    end
    return t;
  endfunction

  function automatic int draw_wait(input int pace);
    return (pace != 0) ? $urandom_range(0, 7) : 0;
  endfunction

  // raw byte driver, fed from the pending byte queue
  always @(posedge clk) begin
    if (rst) begin
      raw_if.valid <= 1'b0;
      raw_if.data_byte <= '0;
      send_wait <= 0;
    end else begin
      if (raw_if.valid && raw_if.ready)
        expected_tags = {expected_tags, deframe_byte(raw_if.data_byte)};
      if (!raw_if.valid || raw_if.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          raw_if.valid <= 1'b0;
        end else if (raw_byte_q.size() != 0) begin
          raw_if.valid <= 1'b1;
          raw_if.data_byte <= raw_byte_q.pop_front();
          send_wait <= draw_wait(send_pace);
        end else begin
          raw_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : result_monitor
    tag_t seen;
    tag_t want;
    int   stall;
    if (rst) begin
      tag_if.ready <= 1'b0;
      recv_wait <= 0;
    end else if (tag_if.valid && tag_if.ready) begin
      seen = '{byte_out: tag_if.byte_out, event_end: tag_if.event_end,
               event_length: tag_if.event_length, header_found: tag_if.header_found,
               subframe_end: tag_if.subframe_end, subframe_length: tag_if.subframe_length,
               bad_layer: tag_if.bad_layer};
      if (expected_tags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("result %0d arrived with nothing expected: byte %h", result_count,
                   seen.byte_out);
      end else begin
        want = expected_tags.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("result %0d: want %h %b/%0d %b %b/%0d %b, got %h %b/%0d %b %b/%0d %b",
                     result_count,
                     want.byte_out, want.event_end, want.event_length, want.header_found,
                     want.subframe_end, want.subframe_length, want.bad_layer,
                     seen.byte_out, seen.event_end, seen.event_length, seen.header_found,
                     seen.subframe_end, seen.subframe_length, seen.bad_layer);
        end
      end
      result_count++;
      stall = draw_wait(recv_pace);
      recv_wait <= stall;
      tag_if.ready <= (stall == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      tag_if.ready <= (recv_wait == 1);
    end else begin
      tag_if.ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("event_and_subframe_deframer verification failed");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    raw_byte_q = {raw_byte_q, b};
    pushed_count++;
  endtask

  // four bytes, most significant first
  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    readback = value;
    case (idx)
      REG_EVENT_TRAILER:    event_trailer_cfg = value;
      REG_HEADER:           header_cfg = value;
      REG_SUBFRAME_TRAILER: subframe_trailer_cfg = value;
      REG_LAYER_MARKER: begin
        layer_cfg = value[7:0];
        readback = {24'd0, value[7:0]};
      end
      default: ;
    endcase
    // register reads back what was written
    @(negedge clk);
    if (prdata !== readback) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("register %0d readback: expected %h got %h", idx, readback, prdata);
    end
  endtask

  task automatic set_regs(input logic [31:0] evt, input logic [31:0] hdr,
                          input logic [31:0] sft, input logic [7:0] lay);
    write_reg(REG_EVENT_TRAILER, evt);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_SUBFRAME_TRAILER, sft);
    write_reg(REG_LAYER_MARKER, {24'd0, lay});
    @(negedge clk);
  endtask

  // block idle: nothing pending, nothing in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (raw_byte_q.size() != 0 || raw_if.valid || expected_tags.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_pace();
    send_pace = $urandom_range(0, 2);
    recv_pace = $urandom_range(0, 2);
  endtask

  // one event: mostly well-formed sub-frames with random content, some noise
  task automatic queue_event();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) != 0) add_word(header_cfg);
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) begin
        add_word(subframe_trailer_cfg);
        add_byte(($urandom_range(0, 6) != 0) ? layer_cfg : 8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) add_word(event_trailer_cfg);
  endtask

  task automatic queue_random(input int n);
    int start;
    start = pushed_count;
    while (pushed_count - start < n) queue_event();
  endtask

  // random match words, sometimes a header that lands on the closing byte
  task automatic random_regs();
    logic [31:0] sft;
    logic [7:0]  lay;
    logic [31:0] hdr;
    sft = $urandom;
    lay = 8'($urandom_range(0, 255));
    hdr = ($urandom_range(0, 3) == 0) ? {sft[15:0], lay, 8'($urandom_range(0, 255))} : $urandom;
    set_regs($urandom, hdr, sft, lay);
  endtask

  // stimulus and final verdict
  initial begin
    raw_if.valid = 1'b0;
    raw_if.data_byte = '0;
    tag_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset words: extremes, header, close, bad layer, event end
    set_pace();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_word(header_cfg);
    add_byte(8'h11);
    add_byte(8'h22);
    add_word(subframe_trailer_cfg);
    add_byte(layer_cfg);
    add_byte(8'h33);
    add_word(subframe_trailer_cfg);
    add_byte(8'h44);
    add_word(event_trailer_cfg);
    queue_random(PhaseItems);
    wait_drained();

    // short event right after an event end, header completed by the closing byte
    set_regs(32'h0000_0012, 32'hFEEE_FF77, SUBFRAME_TRAILER_RST, LAYER_MARKER_RST);
    set_pace();
    add_word(32'h0000_0012);
    add_byte(8'h12);
    add_byte(8'h55);
    add_word(32'hFEEE_FEEE);
    add_byte(8'hFF);
    add_byte(8'h77);
    queue_random(PhaseItems);
    wait_drained();

    // all-zero words
    set_regs(32'h0, 32'h0, 32'h0, 8'h00);
    set_pace();
    add_word(32'h0);
    queue_random(PhaseItems);
    wait_drained();

    // all-ones words
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    set_pace();
    queue_random(PhaseItems);
    wait_drained();

    // closing byte completes a new sub-frame trailer
    set_regs(EVENT_TRAILER_RST, HEADER_RST, 32'hABCD_ABCD, 8'hAB);
    set_pace();
    add_word(32'hABCD_ABCD);
    add_byte(8'hAB);
    add_byte(8'hCD);
    add_byte(8'hAB);
    add_byte(8'hCD);
    add_byte(8'h00);
    queue_random(PhaseItems);
    wait_drained();

    // random words
    repeat (5) begin
      random_regs();
      set_pace();
      queue_random(PhaseItems);
      wait_drained();
    end

    if (mismatch_count == 0 && expected_tags.size() == 0) begin
      $display("event_and_subframe_deframer verification clean");
    end else begin
      $display("event_and_subframe_deframer verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_ifs.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/event_and_subframe_deframer.sv
verif/event_and_subframe_deframer_tb.sv
